// ===== rtl/core/factor_base_smoothness_test_unit_assert.svh =====
// Assertion macros for the smoothness test unit.
`ifndef FACTOR_BASE_SMOOTHNESS_TEST_UNIT_ASSERT_SVH
`define FACTOR_BASE_SMOOTHNESS_TEST_UNIT_ASSERT_SVH
`ifndef SYNTH
`define FBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FBS_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define FBS_ASSERT(lbl, clk, rstn, prop, msg)
`define FBS_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

// ===== rtl/core/fbs_pkg.sv =====
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared types and constants of the smoothness test unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fbs_pkg;
  localparam int unsigned ResultLimit = 15;
  localparam logic [0:0] ActLoad = 1'b0;
  localparam logic [0:0] ActTest = 1'b1;
  localparam logic [0:0] CfgBaseCount = 1'b0;
  localparam logic [0:0] CfgColumnOffset = 1'b1;

  // Divider command and status between the sequencer and the serial divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic        rem_zero;
  } div_rsp_t;
endpackage

// ===== rtl/core/fbs_serial_div.sv =====
// ----------------------------------------------------------------------------
// fbs_serial_div
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "factor_base_smoothness_test_unit_assert.svh"
module fbs_serial_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fbs_pkg::div_req_t req_i,
  output fbs_pkg::div_rsp_t rsp_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [33:0] diff;

  // One shift and subtract step.
  always_comb begin
    trial  = {rem_q[31:0], quo_q[63]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (diff[33]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end else begin
        rem_d = diff[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) dvs_q <= req_i.divisor;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.rem_zero = (rem_q == '0);

  `FBS_ASSERT(a_done_not_busy, clk_i, rst_ni, done_q |-> !busy_q, "done while busy")
  `FBS_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, req_i.start, busy_q, "start did not run")
  `FBS_ASSERT(a_cnt_zero_idle, clk_i, rst_ni, !busy_q |-> (cnt_q == 7'd0), "count left")
endmodule

// ===== rtl/core/factor_base_smoothness_test_unit.sv =====
// ----------------------------------------------------------------------------
// factor_base_smoothness_test_unit
// Trial division smoothness test over a table of factor-base primes.
// ----------------------------------------------------------------------------
// Usage: an input transfer with action_i = 0 writes prime_value_i into slot
// entry_index_i and gives no result. A transfer with action_i = 1 tests
// test_value_i; each dividing prime, up to the result cap, yields one
// result transfer (column, exponent, position), the last carrying last_o
// and smooth_o. A run that finds nothing gives one empty result.
// Configuration writes (index 0 = base_count, 1 = column_offset) are
// taken at any time the port is valid. The unit handles one item at a
// time. A test reads, squares and checks each prime examined, runs each
// division in the serial divider (one quotient bit a cycle), records the
// outcome, and for a large remainder binary searches the table memory;
// each result is then emitted in turn. The worst case is set by the
// divider and the table length. A stalled output holds its result and
// the sequencer waits; input stall is high whenever a run is in progress.
// Reset clears the control state and sets base_count to 1; the table
// content is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "factor_base_smoothness_test_unit_assert.svh"
module factor_base_smoothness_test_unit #(
  parameter int unsigned TABLE_DEPTH = 2048,
  parameter int unsigned MAX_COLUMNS = 96
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [10:0] entry_index_i,
  input  logic [31:0] prime_value_i,
  input  logic [63:0] test_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        factor_valid_o,
  output logic [16:0] factor_column_o,
  output logic [5:0]  exponent_o,
  output logic [3:0]  position_o,
  output logic        smooth_o,
  output logic        last_o
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CapI = (MAX_COLUMNS < fbs_pkg::ResultLimit) ?
                                 MAX_COLUMNS : fbs_pkg::ResultLimit;
  localparam logic [3:0] Cap = 4'(CapI);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_CHK = 4'd3,
                         S_DIV = 4'd4, S_DIVW = 4'd5, S_REC = 4'd6, S_LRD = 4'd7,
                         S_LRDW = 4'd8, S_LCHK = 4'd9, S_BRD = 4'd10,
                         S_BRDW = 4'd11, S_BCHK = 4'd12, S_FIN = 4'd13,
                         S_EMIT = 4'd14, S_MUL = 4'd15;

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_q;
  logic [AW-1:0] raddr;
  logic [11:0] base_q;
  logic [15:0] coff_q;
  logic [3:0]  st_q, st_d;
  logic [CW-1:0] nfb, idx_q, idx_d, lo_q, lo_d, hi_q, hi_d, mid;
  logic [63:0] v_q, v_d, qsq_q;
  logic [31:0] q_q, q_d;
  logic [5:0]  e_q, e_d;
  logic [3:0]  n_q, n_d;
  logic        ovf_q, ovf_d, smooth_q, smooth_d;
  logic [16:0] col_mem [fbs_pkg::ResultLimit];
  logic [5:0]  exp_mem [fbs_pkg::ResultLimit];
  logic        rec_we;
  logic [16:0] rec_col;
  logic [5:0]  rec_exp;
  logic [3:0]  k_q, k_d;
  logic        ov_q, ov_d;
  fbs_pkg::div_req_t dreq;
  fbs_pkg::div_rsp_t drsp;
  logic        load_ok;

  assign nfb = (32'(base_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(base_q);
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != S_IDLE);
  assign load_ok = (32'(entry_index_i) < 32'(TABLE_DEPTH));

  fbs_serial_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 12'd1;
      coff_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fbs_pkg::CfgBaseCount) base_q <= cfg_data_i[11:0];
      else coff_q <= cfg_data_i;
    end
  end

  // Table memory, one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o && action_i == fbs_pkg::ActLoad && load_ok)
      mem[AW'(entry_index_i)] <= prime_value_i;
    rd_q <= mem[raddr];
  end

  // Factor record file.
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      col_mem[n_q] <= rec_col;
      exp_mem[n_q] <= rec_exp;
    end
    qsq_q <= 64'(q_q) * 64'(q_q);
  end

  // Sequencer.
  always_comb begin
    st_d = st_q; idx_d = idx_q; lo_d = lo_q; hi_d = hi_q; v_d = v_q; q_d = q_q;
    e_d = e_q; n_d = n_q; ovf_d = ovf_q; smooth_d = smooth_q; k_d = k_q; ov_d = ov_q;
    raddr = AW'(idx_q);
    dreq = '{start: 1'b0, dividend: v_q, divisor: q_q};
    rec_we = 1'b0; rec_col = 17'(coff_q) + 17'(idx_q); rec_exp = e_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i && action_i == fbs_pkg::ActTest) begin
          v_d = test_value_i; idx_d = '0; n_d = '0; ovf_d = 1'b0; st_d = S_RD;
        end
      end
      S_RD: begin
        if (idx_q < nfb && v_q > 64'd1 && !ovf_q) st_d = S_RDW;
        else st_d = S_FIN;
      end
      S_RDW: begin q_d = rd_q; st_d = S_MUL; end
      S_MUL: st_d = S_CHK;
      S_CHK: begin
        if (q_q < 32'd2) begin idx_d = idx_q + 1'b1; st_d = S_RD; end
        else if (qsq_q > v_q || q_q[31:16] != '0 && qsq_q < 64'(q_q)) begin
          st_d = S_LRD;
        end else begin
          e_d = '0; dreq.start = 1'b1; st_d = S_DIVW;
        end
      end
      S_DIVW: begin
        if (drsp.done) begin
          if (drsp.rem_zero) begin
            v_d = drsp.quotient; e_d = e_q + 1'b1;
            dreq = '{start: 1'b1, dividend: drsp.quotient, divisor: q_q};
          end else st_d = S_REC;
        end
      end
      S_REC: begin
        if (e_q != '0) begin
          if (n_q >= Cap) ovf_d = 1'b1;
          else begin rec_we = 1'b1; n_d = n_q + 1'b1; end
        end
        idx_d = idx_q + 1'b1; st_d = S_RD;
      end
      S_LRD: begin raddr = AW'(nfb - 1'b1); st_d = S_LRDW; end
      // Hold the address so that the read data stays valid for the check.
      S_LRDW: begin raddr = AW'(nfb - 1'b1); st_d = S_LCHK; end
      S_LCHK: begin
        if (v_q <= 64'(rd_q)) begin lo_d = idx_q; hi_d = nfb; st_d = S_BRD; end
        else st_d = S_FIN;
      end
      S_BRD: begin
        raddr = AW'(mid);
        if (lo_q < hi_q) st_d = S_BRDW;
        else begin
          raddr = AW'(lo_q);
          st_d = (lo_q < nfb) ? S_DIV : S_FIN;
        end
      end
      S_BRDW: begin raddr = AW'(mid); st_d = S_BCHK; end
      S_BCHK: begin
        if (64'(rd_q) < v_q) lo_d = mid + 1'b1; else hi_d = mid;
        st_d = S_BRD;
      end
      S_DIV: begin
        // Final probe of the binary search: read data for slot lo is ready.
        if (64'(rd_q) == v_q) begin
          if (n_q >= Cap) ovf_d = 1'b1;
          else begin
            rec_we = 1'b1; rec_col = 17'(coff_q) + 17'(lo_q); rec_exp = 6'd1;
            n_d = n_q + 1'b1; v_d = 64'd1;
          end
        end
        st_d = S_FIN;
      end
      S_FIN: begin
        smooth_d = !ovf_q && v_q == 64'd1; k_d = '0; ov_d = 1'b0; st_d = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_q) ov_d = 1'b1;
        else if (!out_stall_i) begin
          ov_d = 1'b0;
          if (n_q == '0 || k_q == n_q - 1'b1) st_d = S_IDLE;
          else k_d = k_q + 1'b1;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; n_q <= '0; k_q <= '0; ov_q <= 1'b0; ovf_q <= 1'b0;
      smooth_q <= 1'b0; v_q <= '0; idx_q <= '0;
    end else begin
      st_q <= st_d; n_q <= n_d; k_q <= k_d; ov_q <= ov_d; ovf_q <= ovf_d;
      smooth_q <= smooth_d; v_q <= v_d; idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; q_q <= q_d; e_q <= e_d;
  end

  // Result fields.
  logic fin;
  assign fin = (n_q == '0) || (k_q == n_q - 1'b1);
  assign out_valid_o     = (st_q == S_EMIT) && ov_q;
  assign factor_valid_o  = (n_q != '0);
  assign factor_column_o = (n_q != '0) ? col_mem[k_q] : '0;
  assign exponent_o      = (n_q != '0) ? exp_mem[k_q] : '0;
  assign position_o      = (n_q != '0) ? k_q : '0;
  assign smooth_o        = fin && smooth_q;
  assign last_o          = fin;

  `FBS_ASSERT(a_no_in_busy, clk_i, rst_ni, (st_q != S_IDLE) |-> in_stall_o, "accept busy")
  `FBS_ASSERT(a_n_cap, clk_i, rst_ni, n_q <= Cap, "factor count beyond cap")
  `FBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(k_q), "result dropped")
endmodule
